@@ src/hte_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hte_pkg
// Types, constants and the arctangent table of the helix extrapolation block.
// ----------------------------------------------------------------------------
package hte_pkg;

   localparam int unsigned CORDIC_STEPS_DEF = 24;
   localparam int unsigned FIELD_W          = 16;
   localparam int unsigned FQ_W             = 18;
   localparam int unsigned NMAG_W           = 49;
   localparam int unsigned PHASE_FRAC       = 13;
   localparam int unsigned NUM1_W           = NMAG_W + PHASE_FRAC;
   localparam int unsigned DEN1_W           = 32;
   localparam int unsigned NUM2_W           = 64;
   localparam int unsigned CORD_W           = 34;
   localparam int unsigned SHIFT_BITS       = 44;

   localparam logic [FIELD_W-1:0]       FIELD_RESET  = 16'd8192;
   localparam logic [31:0]              TURN_GAIN    = 32'd4197025167;
   localparam logic [30:0]              HALF_PI_Q30  = 31'd1686629713;
   localparam logic signed [CORD_W-1:0] CORDIC_K_Q30 = 34'sd652032874;
   localparam logic [18:0]              RADIUS_Q2    = 19'd341561;

   typedef enum logic [1:0] {
      ST_OK,
      ST_PT_ZERO,
      ST_PZ_ZERO,
      ST_NO_BEND
   } status_type;

   typedef struct packed {
      logic signed [31:0] x0;
      logic signed [31:0] y0;
      logic signed [31:0] z0;
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic signed [31:0] pz;
      logic signed [2:0]  q;
      logic [FQ_W-1:0]    fq;
      logic               pneg;
      status_type         status;
   } track_type;

   // radians Q30
   function automatic logic signed [CORD_W-1:0] atan_q30(input int unsigned k);
      logic signed [CORD_W-1:0] a;
      case (k)
         0:       a = 34'sd843314856;
         1:       a = 34'sd497837829;
         2:       a = 34'sd263043836;
         3:       a = 34'sd133525158;
         4:       a = 34'sd67021686;
         5:       a = 34'sd33543515;
         6:       a = 34'sd16775850;
         7:       a = 34'sd8388437;
         8:       a = 34'sd4194282;
         9:       a = 34'sd2097149;
         10:      a = 34'sd1048575;
         11:      a = 34'sd524287;
         12:      a = 34'sd262143;
         13:      a = 34'sd131071;
         14:      a = 34'sd65535;
         15:      a = 34'sd32767;
         16:      a = 34'sd16383;
         17:      a = 34'sd8191;
         18:      a = 34'sd4095;
         19:      a = 34'sd2047;
         20:      a = 34'sd1023;
         21:      a = 34'sd511;
         22:      a = 34'sd255;
         23:      a = 34'sd127;
         24:      a = 34'sd63;
         25:      a = 34'sd31;
         26:      a = 34'sd15;
         27:      a = 34'sd8;
         28:      a = 34'sd4;
         29:      a = 34'sd2;
         30:      a = 34'sd1;
         default: a = 34'sd0;
      endcase
      return a;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
      logic signed [31:0] r;
      if (v > 36'sd2147483647) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -36'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

@@ src/hte_req_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hte_req_if
// Track channel: valid/ready handshake with start position, momentum, charge.
// ----------------------------------------------------------------------------
interface hte_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [31:0] pos_z;
   logic signed [31:0] mom_x;
   logic signed [31:0] mom_y;
   logic signed [31:0] mom_z;
   logic signed [2:0]  particle_charge;

   modport source (
      output valid, pos_x, pos_y, pos_z, mom_x, mom_y, mom_z, particle_charge,
      input  ready
   );
   modport sink (
      input  valid, pos_x, pos_y, pos_z, mom_x, mom_y, mom_z, particle_charge,
      output ready
   );
endinterface

@@ src/hte_rsp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hte_rsp_if
// Result channel: valid/ready handshake with extrapolated track and status.
// ----------------------------------------------------------------------------
interface hte_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] new_x;
   logic signed [31:0] new_y;
   logic signed [31:0] new_z;
   logic signed [31:0] new_px;
   logic signed [31:0] new_py;
   logic signed [31:0] new_pz;
   logic [1:0]         status;

   modport source (
      output valid, new_x, new_y, new_z, new_px, new_py, new_pz, status,
      input  ready
   );
   modport sink (
      input  valid, new_x, new_y, new_z, new_px, new_py, new_pz, status,
      output ready
   );
endinterface

@@ src/hte_div_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hte_div_cell
// One restoring division step per cell: one quotient bit for each lane.
// ----------------------------------------------------------------------------
module hte_div_cell #(
   parameter int NUM_W  = 62,
   parameter int DEN_W  = 32,
   parameter int LANES  = 1,
   parameter int SIDE_W = 1
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            enable,
   input  logic                            up_valid,
   input  logic [DEN_W-1:0]                up_den,
   input  logic [LANES-1:0][NUM_W-1:0]     up_num,
   input  logic [LANES-1:0][DEN_W-1:0]     up_rem,
   input  logic [SIDE_W-1:0]               up_side,
   output logic                            dn_valid,
   output logic [DEN_W-1:0]                dn_den,
   output logic [LANES-1:0][NUM_W-1:0]     dn_num,
   output logic [LANES-1:0][DEN_W-1:0]     dn_rem,
   output logic [SIDE_W-1:0]               dn_side
);

   logic [LANES-1:0][DEN_W:0]     trial;
   logic [LANES-1:0][DEN_W:0]     diff;
   logic [LANES-1:0]              take;
   logic [LANES-1:0][NUM_W-1:0]   num_in;
   logic [LANES-1:0][DEN_W-1:0]   rem_in;

   logic                          valid_ff;
   logic [DEN_W-1:0]              den_ff;
   logic [LANES-1:0][NUM_W-1:0]   num_ff;
   logic [LANES-1:0][DEN_W-1:0]   rem_ff;
   logic [SIDE_W-1:0]             side_ff;

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         trial[l]  = {up_rem[l], up_num[l][NUM_W-1]};
         diff[l]   = trial[l] - {1'b0, up_den};
         take[l]   = (trial[l] >= {1'b0, up_den});
         rem_in[l] = take[l] ? diff[l][DEN_W-1:0] : trial[l][DEN_W-1:0];
         num_in[l] = {up_num[l][NUM_W-2:0], take[l]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         den_ff  <= up_den;
         num_ff  <= num_in;
         rem_ff  <= rem_in;
         side_ff <= up_side;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_den   = den_ff;
   assign dn_num   = num_ff;
   assign dn_rem   = rem_ff;
   assign dn_side  = side_ff;

endmodule

@@ src/hte_cordic_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hte_cordic_cell
// One rotation-mode CORDIC micro-rotation, registered.
// ----------------------------------------------------------------------------
module hte_cordic_cell import hte_pkg::*; #(
   parameter int STAGE  = 0,
   parameter int SIDE_W = 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     enable,
   input  logic                     up_valid,
   input  logic signed [CORD_W-1:0] up_x,
   input  logic signed [CORD_W-1:0] up_y,
   input  logic signed [CORD_W-1:0] up_z,
   input  logic [SIDE_W-1:0]        up_side,
   output logic                     dn_valid,
   output logic signed [CORD_W-1:0] dn_x,
   output logic signed [CORD_W-1:0] dn_y,
   output logic signed [CORD_W-1:0] dn_z,
   output logic [SIDE_W-1:0]        dn_side
);

   localparam int unsigned              K     = STAGE % 32;
   localparam logic signed [CORD_W-1:0] ANGLE = atan_q30(K);

   logic signed [CORD_W-1:0] dx;
   logic signed [CORD_W-1:0] dy;
   logic signed [CORD_W-1:0] x_in;
   logic signed [CORD_W-1:0] y_in;
   logic signed [CORD_W-1:0] z_in;

   logic                     valid_ff;
   logic signed [CORD_W-1:0] x_ff;
   logic signed [CORD_W-1:0] y_ff;
   logic signed [CORD_W-1:0] z_ff;
   logic [SIDE_W-1:0]        side_ff;

   always_comb begin
      dx = up_y >>> K;
      dy = up_x >>> K;
      if (!up_z[CORD_W-1]) begin
         x_in = up_x - dx;
         y_in = up_y + dy;
         z_in = up_z - ANGLE;
      end else begin
         x_in = up_x + dx;
         y_in = up_y - dy;
         z_in = up_z + ANGLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
         side_ff <= up_side;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_x     = x_ff;
   assign dn_y     = y_ff;
   assign dn_z     = z_ff;
   assign dn_side  = side_ff;

endmodule

@@ src/helix_track_extrapolation.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// helix_track_extrapolation
// Carries a charged track along a helix in an axial field to the plane z = 0.
// ----------------------------------------------------------------------------
// Tracks enter on req_channel and results leave on rsp_channel, both
// valid/ready; a transfer happens when valid and ready are high at a clock
// edge. csr_write_enable/csr_write_data load the field strength (1/4096 T);
// the user must load it only while no track is in flight, as the block
// does not enforce this. One track is taken every cycle unless stalled.
// The pipe holds two chains of one-bit division cells (62 for the turning
// phase, 64 for the radial shifts) and the CORDIC cell row.
// The whole pipe moves as one: when the result register holds a track the
// receiver has not taken, every stage holds and req_channel.ready is low.
// Reset empties the pipe and sets the field to 2 T.
// Status: 0 ok, 1 pt zero, 2 pz zero, 3 charge or field zero; on a non-zero
// status the track passes through unchanged.
// ----------------------------------------------------------------------------
module helix_track_extrapolation import hte_pkg::*; #(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   hte_req_if.sink            req_channel,
   hte_rsp_if.source          rsp_channel,
   input  logic               csr_write_enable,
   input  logic [FIELD_W-1:0] csr_write_data
);

   localparam int TRK_W = $bits(track_type);

   typedef struct packed {
      logic      flip;
      track_type trk;
   } cord_side_type;

   typedef struct packed {
      logic               negx;
      logic               negy;
      logic signed [33:0] npx;
      logic signed [33:0] npy;
      track_type          trk;
   } mom_side_type;

   localparam int CSIDE_W = $bits(cord_side_type);
   localparam int MSIDE_W = $bits(mom_side_type);

   logic adv;
   logic [FIELD_W-1:0] field_ff;

   // accept stage
   logic [2:0]         a_absq;
   track_type          a_trk_in;
   logic [31:0]        a_absz_in;
   logic [31:0]        a_abspz_in;
   logic               a_valid_ff;
   track_type          a_trk_ff;
   logic [31:0]        a_absz_ff;
   logic [31:0]        a_abspz_ff;

   // numerator
   logic               b_valid_ff;
   track_type          b_trk_ff;
   logic [NMAG_W-1:0]  b_nmag_ff;
   logic [31:0]        b_abspz_ff;

   // phase divider chain
   logic                         d1_valid [0:NUM1_W];
   logic [DEN1_W-1:0]            d1_den   [0:NUM1_W];
   logic [0:0][NUM1_W-1:0]       d1_num   [0:NUM1_W];
   logic [0:0][DEN1_W-1:0]       d1_rem   [0:NUM1_W];
   logic [TRK_W-1:0]             d1_side  [0:NUM1_W];
   track_type                    d1_trk;

   // phase scaling
   logic [63:0]        c_plo_full;
   logic [61:0]        c_phi_full;
   logic               c_valid_ff;
   track_type          c_trk_ff;
   logic [31:0]        c_phi_ff;
   logic [31:0]        c_plo_ff;

   // quadrant reduction
   logic [31:0]        d_ph;
   logic signed [32:0] d_r;
   logic signed [32:0] d_rabs;
   logic               d_flip;
   logic               d_valid_ff;
   track_type          d_trk_ff;
   logic [30:0]        d_absr_ff;
   logic               d_rneg_ff;
   logic               d_flip_ff;

   logic               e_valid_ff;
   track_type          e_trk_ff;
   logic [61:0]        e_zmul_ff;
   logic               e_rneg_ff;
   logic               e_flip_ff;

   logic [61:0]              f_zsum;
   logic signed [CORD_W-1:0] f_zmag;
   logic                     f_valid_ff;
   cord_side_type            f_side_ff;
   logic signed [CORD_W-1:0] f_z_ff;

   // CORDIC row
   logic                     cr_valid [0:CORDIC_STEPS];
   logic signed [CORD_W-1:0] cr_x     [0:CORDIC_STEPS];
   logic signed [CORD_W-1:0] cr_y     [0:CORDIC_STEPS];
   logic signed [CORD_W-1:0] cr_z     [0:CORDIC_STEPS];
   logic [CSIDE_W-1:0]       cr_side  [0:CORDIC_STEPS];
   cord_side_type            cr_out;

   logic                     g_valid_ff;
   track_type                g_trk_ff;
   logic signed [CORD_W-1:0] g_cx_ff;
   logic signed [CORD_W-1:0] g_cy_ff;

   // momentum rotation
   logic signed [CORD_W-1:0] h_omc;
   logic signed [CORD_W-1:0] h_s;
   logic                     h_valid_ff;
   track_type                h_trk_ff;
   logic signed [63:0]       h_pxcx_ff;
   logic signed [63:0]       h_pycy_ff;
   logic signed [63:0]       h_pycx_ff;
   logic signed [63:0]       h_pxcy_ff;
   logic signed [31:0]       h_s28_ff;
   logic signed [31:0]       h_omc28_ff;

   logic signed [63:0]       i_sx;
   logic signed [63:0]       i_sy;
   logic                     i_valid_ff;
   track_type                i_trk_ff;
   logic signed [33:0]       i_npx_ff;
   logic signed [33:0]       i_npy_ff;
   logic signed [31:0]       i_s28_ff;
   logic signed [31:0]       i_omc28_ff;

   logic                     j_valid_ff;
   track_type                j_trk_ff;
   logic signed [33:0]       j_npx_ff;
   logic signed [33:0]       j_npy_ff;
   logic signed [63:0]       j_a_ff;
   logic signed [63:0]       j_b_ff;
   logic signed [63:0]       j_c_ff;
   logic signed [63:0]       j_d_ff;

   logic signed [64:0]       k_mx;
   logic signed [64:0]       k_my;
   logic signed [64:0]       k_mxa;
   logic signed [64:0]       k_mya;
   mom_side_type             k_side_in;
   logic                     k_valid_ff;
   mom_side_type             k_side_ff;
   logic [NUM2_W-1:0]        k_mxmag_ff;
   logic [NUM2_W-1:0]        k_mymag_ff;

   // shift divider chain, two lanes
   logic                        d2_valid [0:NUM2_W];
   logic [FQ_W-1:0]             d2_den   [0:NUM2_W];
   logic [1:0][NUM2_W-1:0]      d2_num   [0:NUM2_W];
   logic [1:0][FQ_W-1:0]        d2_rem   [0:NUM2_W];
   logic [MSIDE_W-1:0]          d2_side  [0:NUM2_W];
   mom_side_type                d2_out;

   logic                     l_valid_ff;
   mom_side_type             l_side_ff;
   logic [1:0][62:0]         l_prod_ff;
   logic [1:0]               l_sat_ff;

   // result register
   logic [62:0]              m_dsum [2];
   logic signed [35:0]       m_d    [2];
   logic signed [35:0]       m_sum  [2];
   logic signed [31:0]       m_pos  [2];
   logic signed [31:0]       m_new  [2];
   logic                     m_neg  [2];
   logic                     rsp_valid_ff;
   logic signed [31:0]       rsp_x_ff;
   logic signed [31:0]       rsp_y_ff;
   logic signed [31:0]       rsp_z_ff;
   logic signed [31:0]       rsp_px_ff;
   logic signed [31:0]       rsp_py_ff;
   logic signed [31:0]       rsp_pz_ff;
   status_type               rsp_status_ff;

   assign adv               = !rsp_valid_ff || rsp_channel.ready;
   assign req_channel.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         field_ff <= FIELD_RESET;
      end else if (csr_write_enable) begin
         field_ff <= csr_write_data;
      end
   end

   // ---------------------------------------------------------------- accept
   always_comb begin
      a_absq = req_channel.particle_charge[2] ? 3'(-req_channel.particle_charge)
                                              : req_channel.particle_charge;
      a_trk_in.x0   = req_channel.pos_x;
      a_trk_in.y0   = req_channel.pos_y;
      a_trk_in.z0   = req_channel.pos_z;
      a_trk_in.px   = req_channel.mom_x;
      a_trk_in.py   = req_channel.mom_y;
      a_trk_in.pz   = req_channel.mom_z;
      a_trk_in.q    = req_channel.particle_charge;
      a_trk_in.fq   = FQ_W'(field_ff) * FQ_W'(a_absq);
      a_trk_in.pneg = ((req_channel.pos_z[31] == req_channel.particle_charge[2])
                       != req_channel.mom_z[31]);
      if (req_channel.mom_x == '0 && req_channel.mom_y == '0) begin
         a_trk_in.status = ST_PT_ZERO;
      end else if (req_channel.mom_z == '0) begin
         a_trk_in.status = ST_PZ_ZERO;
      end else if (req_channel.particle_charge == '0 || field_ff == '0) begin
         a_trk_in.status = ST_NO_BEND;
      end else begin
         a_trk_in.status = ST_OK;
      end
      a_absz_in  = req_channel.pos_z[31] ? 32'(-req_channel.pos_z) : req_channel.pos_z;
      a_abspz_in = req_channel.mom_z[31] ? 32'(-req_channel.mom_z) : req_channel.mom_z;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
         f_valid_ff <= 1'b0;
         g_valid_ff <= 1'b0;
         h_valid_ff <= 1'b0;
         i_valid_ff <= 1'b0;
         j_valid_ff <= 1'b0;
         k_valid_ff <= 1'b0;
         l_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= req_channel.valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= d1_valid[NUM1_W];
         d_valid_ff <= c_valid_ff;
         e_valid_ff <= d_valid_ff;
         f_valid_ff <= e_valid_ff;
         g_valid_ff <= cr_valid[CORDIC_STEPS];
         h_valid_ff <= g_valid_ff;
         i_valid_ff <= h_valid_ff;
         j_valid_ff <= i_valid_ff;
         k_valid_ff <= j_valid_ff;
         l_valid_ff <= d2_valid[NUM2_W];
         rsp_valid_ff <= l_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_trk_ff   <= a_trk_in;
         a_absz_ff  <= a_absz_in;
         a_abspz_ff <= a_abspz_in;
         b_trk_ff   <= a_trk_ff;
         b_nmag_ff  <= NMAG_W'(a_trk_ff.fq) * NMAG_W'(a_absz_ff);
         b_abspz_ff <= a_abspz_ff;
      end
   end

   // ---------------------------------------------------------- phase divide
   assign d1_valid[0] = b_valid_ff;
   assign d1_den[0]   = b_abspz_ff;
   assign d1_num[0]   = {b_nmag_ff, {PHASE_FRAC{1'b0}}};
   assign d1_rem[0]   = '0;
   assign d1_side[0]  = b_trk_ff;

   for (genvar i = 0; i < NUM1_W; i++) begin : g_div1
      hte_div_cell #(
         .NUM_W  (NUM1_W),
         .DEN_W  (DEN1_W),
         .LANES  (1),
         .SIDE_W (TRK_W)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .enable   (adv),
         .up_valid (d1_valid[i]),
         .up_den   (d1_den[i]),
         .up_num   (d1_num[i]),
         .up_rem   (d1_rem[i]),
         .up_side  (d1_side[i]),
         .dn_valid (d1_valid[i+1]),
         .dn_den   (d1_den[i+1]),
         .dn_num   (d1_num[i+1]),
         .dn_rem   (d1_rem[i+1]),
         .dn_side  (d1_side[i+1])
      );
   end

   assign d1_trk     = track_type'(d1_side[NUM1_W]);
   assign c_phi_full = 62'(d1_num[NUM1_W][0][NUM1_W-1:32]) * 62'(TURN_GAIN);
   assign c_plo_full = 64'(d1_num[NUM1_W][0][31:0]) * 64'(TURN_GAIN);

   // ------------------------------------------------------- phase to angle
   always_comb begin
      d_ph = c_phi_ff + c_plo_ff;
      if (c_trk_ff.pneg && c_trk_ff.z0 != '0 && c_trk_ff.fq != '0) begin
         d_ph = 32'(-d_ph);
      end
      d_r    = $signed({d_ph[31], d_ph});
      d_flip = 1'b0;
      if (d_r > 33'sd1073741824) begin
         d_r    = d_r - 33'sd2147483648;
         d_flip = 1'b1;
      end else if (d_r < -33'sd1073741824) begin
         d_r    = d_r + 33'sd2147483648;
         d_flip = 1'b1;
      end
      d_rabs = d_r[32] ? -d_r : d_r;
   end

   assign f_zsum = e_zmul_ff + 62'd536870912;
   assign f_zmag = $signed({2'b00, f_zsum[61:30]});

   always_ff @(posedge clock) begin
      if (adv) begin
         c_trk_ff  <= d1_trk;
         c_phi_ff  <= c_phi_full[31:0];
         c_plo_ff  <= c_plo_full[63:32];
         d_trk_ff  <= c_trk_ff;
         d_absr_ff <= d_rabs[30:0];
         d_rneg_ff <= d_r[32];
         d_flip_ff <= d_flip;
         e_trk_ff  <= d_trk_ff;
         e_zmul_ff <= 62'(d_absr_ff) * 62'(HALF_PI_Q30);
         e_rneg_ff <= d_rneg_ff;
         e_flip_ff <= d_flip_ff;
         f_side_ff.trk  <= e_trk_ff;
         f_side_ff.flip <= e_flip_ff;
         f_z_ff <= e_rneg_ff ? -f_zmag : f_zmag;
      end
   end

   // ------------------------------------------------------------- CORDIC
   assign cr_valid[0] = f_valid_ff;
   assign cr_x[0]     = CORDIC_K_Q30;
   assign cr_y[0]     = '0;
   assign cr_z[0]     = f_z_ff;
   assign cr_side[0]  = f_side_ff;

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
      hte_cordic_cell #(
         .STAGE  (i),
         .SIDE_W (CSIDE_W)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .enable   (adv),
         .up_valid (cr_valid[i]),
         .up_x     (cr_x[i]),
         .up_y     (cr_y[i]),
         .up_z     (cr_z[i]),
         .up_side  (cr_side[i]),
         .dn_valid (cr_valid[i+1]),
         .dn_x     (cr_x[i+1]),
         .dn_y     (cr_y[i+1]),
         .dn_z     (cr_z[i+1]),
         .dn_side  (cr_side[i+1])
      );
   end

   assign cr_out = cord_side_type'(cr_side[CORDIC_STEPS]);

   // ---------------------------------------------------- momentum rotation
   assign h_omc = (34'sd1073741824 - g_cx_ff) >>> 2;
   assign h_s   = g_cy_ff >>> 2;
   assign i_sx  = h_pxcx_ff + h_pycy_ff + 64'sd536870912;
   assign i_sy  = h_pycx_ff - h_pxcy_ff + 64'sd536870912;

   always_ff @(posedge clock) begin
      if (adv) begin
         g_trk_ff   <= cr_out.trk;
         g_cx_ff    <= cr_out.flip ? -cr_x[CORDIC_STEPS] : cr_x[CORDIC_STEPS];
         g_cy_ff    <= cr_out.flip ? -cr_y[CORDIC_STEPS] : cr_y[CORDIC_STEPS];
         h_trk_ff   <= g_trk_ff;
         h_pxcx_ff  <= 64'(g_trk_ff.px) * 64'(g_cx_ff);
         h_pycy_ff  <= 64'(g_trk_ff.py) * 64'(g_cy_ff);
         h_pycx_ff  <= 64'(g_trk_ff.py) * 64'(g_cx_ff);
         h_pxcy_ff  <= 64'(g_trk_ff.px) * 64'(g_cy_ff);
         h_s28_ff   <= h_s[31:0];
         h_omc28_ff <= h_omc[31:0];
         i_trk_ff   <= h_trk_ff;
         i_npx_ff   <= i_sx[63:30];
         i_npy_ff   <= i_sy[63:30];
         i_s28_ff   <= h_s28_ff;
         i_omc28_ff <= h_omc28_ff;
         j_trk_ff   <= i_trk_ff;
         j_npx_ff   <= i_npx_ff;
         j_npy_ff   <= i_npy_ff;
         j_a_ff     <= 64'(i_npx_ff) * 64'(i_s28_ff);
         j_b_ff     <= 64'(i_npy_ff) * 64'(i_omc28_ff);
         j_c_ff     <= 64'(i_npy_ff) * 64'(i_s28_ff);
         j_d_ff     <= 64'(i_npx_ff) * 64'(i_omc28_ff);
      end
   end

   // ---------------------------------------------------- circle displacement
   always_comb begin
      k_mx  = 65'(j_b_ff) - 65'(j_a_ff);
      k_my  = -(65'(j_c_ff) + 65'(j_d_ff));
      k_mxa = k_mx[64] ? -k_mx : k_mx;
      k_mya = k_my[64] ? -k_my : k_my;
      k_side_in.negx = (k_mx != '0) && (k_mx[64] == j_trk_ff.q[2]);
      k_side_in.negy = (k_my != '0) && (k_my[64] == j_trk_ff.q[2]);
      k_side_in.npx  = j_npx_ff;
      k_side_in.npy  = j_npy_ff;
      k_side_in.trk  = j_trk_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         k_side_ff  <= k_side_in;
         k_mxmag_ff <= k_mxa[NUM2_W-1:0];
         k_mymag_ff <= k_mya[NUM2_W-1:0];
      end
   end

   assign d2_valid[0] = k_valid_ff;
   assign d2_den[0]   = k_side_ff.trk.fq;
   assign d2_num[0]   = {k_mymag_ff, k_mxmag_ff};
   assign d2_rem[0]   = '0;
   assign d2_side[0]  = k_side_ff;

   for (genvar i = 0; i < NUM2_W; i++) begin : g_div2
      hte_div_cell #(
         .NUM_W  (NUM2_W),
         .DEN_W  (FQ_W),
         .LANES  (2),
         .SIDE_W (MSIDE_W)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .enable   (adv),
         .up_valid (d2_valid[i]),
         .up_den   (d2_den[i]),
         .up_num   (d2_num[i]),
         .up_rem   (d2_rem[i]),
         .up_side  (d2_side[i]),
         .dn_valid (d2_valid[i+1]),
         .dn_den   (d2_den[i+1]),
         .dn_num   (d2_num[i+1]),
         .dn_rem   (d2_rem[i+1]),
         .dn_side  (d2_side[i+1])
      );
   end

   assign d2_out = mom_side_type'(d2_side[NUM2_W]);

   always_ff @(posedge clock) begin
      if (adv) begin
         l_side_ff <= d2_out;
         for (int l = 0; l < 2; l++) begin
            l_prod_ff[l] <= 63'(d2_num[NUM2_W][l][SHIFT_BITS-1:0]) * 63'(RADIUS_Q2);
            l_sat_ff[l]  <= |d2_num[NUM2_W][l][NUM2_W-1:SHIFT_BITS];
         end
      end
   end

   // ------------------------------------------------------- result register
   assign m_pos[0] = l_side_ff.trk.x0;
   assign m_pos[1] = l_side_ff.trk.y0;
   assign m_neg[0] = l_side_ff.negx;
   assign m_neg[1] = l_side_ff.negy;

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         m_dsum[l] = l_prod_ff[l] + 63'd536870912;
         m_d[l]    = $signed({3'b000, m_dsum[l][62:30]});
         m_sum[l]  = m_neg[l] ? 36'(m_pos[l]) - m_d[l] : 36'(m_pos[l]) + m_d[l];
         if (l_sat_ff[l]) begin
            m_new[l] = m_neg[l] ? 32'sh80000000 : 32'sh7FFFFFFF;
         end else begin
            m_new[l] = sat32(m_sum[l]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_pz_ff     <= l_side_ff.trk.pz;
         rsp_status_ff <= l_side_ff.trk.status;
         if (l_side_ff.trk.status == ST_OK) begin
            rsp_x_ff  <= m_new[0];
            rsp_y_ff  <= m_new[1];
            rsp_z_ff  <= '0;
            rsp_px_ff <= sat32(36'(l_side_ff.npx));
            rsp_py_ff <= sat32(36'(l_side_ff.npy));
         end else begin
            rsp_x_ff  <= l_side_ff.trk.x0;
            rsp_y_ff  <= l_side_ff.trk.y0;
            rsp_z_ff  <= l_side_ff.trk.z0;
            rsp_px_ff <= l_side_ff.trk.px;
            rsp_py_ff <= l_side_ff.trk.py;
         end
      end
   end

   assign rsp_channel.valid  = rsp_valid_ff;
   assign rsp_channel.new_x  = rsp_x_ff;
   assign rsp_channel.new_y  = rsp_y_ff;
   assign rsp_channel.new_z  = rsp_z_ff;
   assign rsp_channel.new_px = rsp_px_ff;
   assign rsp_channel.new_py = rsp_py_ff;
   assign rsp_channel.new_pz = rsp_pz_ff;
   assign rsp_channel.status = rsp_status_ff;

`ifndef ASSERT_OFF
   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (rsp_channel.valid && !rsp_channel.ready) |-> !req_channel.ready)
      else $error("track taken while result stalled");

   a_pipe_holds: assert property (@(posedge clock) disable iff (reset)
      !adv |=> ($stable(c_valid_ff) && $stable(l_valid_ff) && $stable(g_valid_ff)))
      else $error("pipeline moved during stall");

   a_ok_on_plane: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == ST_OK) |-> (rsp_z_ff == '0))
      else $error("good track not on z = 0");
`endif

endmodule
